@@ sv/psa_pkg.sv @@
// Shared types, constants and status codes for the partitioned storage accounting block
`default_nettype none

package psa_pkg;

    localparam int LVL_W   = 48;
    localparam int KEY_W   = 16;
    localparam int TIME_W  = 32;
    localparam int NET_W   = 53;
    localparam int DELTA_W = 52;
    localparam int MAG_W   = 51;
    localparam int PROD_W  = 82;

    localparam int PARTITIONS_DEF       = 16;
    localparam int TICKS_PER_SECOND_DEF = 1000000;

    localparam logic [LVL_W-1:0] LVL_MAX  = {LVL_W{1'b1}};
    localparam logic [MAG_W-1:0] DMAX_MAG = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic signed [NET_W-1:0] NET_MAX = {1'b0, {(NET_W-1){1'b1}}};
    localparam logic signed [NET_W-1:0] NET_MIN = {1'b1, {(NET_W-1){1'b0}}};

    localparam logic OP_RATE = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    typedef logic [LVL_W-1:0]          level_t;
    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic signed [NET_W-1:0]   net_t;

    typedef enum logic [2:0] {
        ST_APPLIED    = 3'd0,
        ST_CREATED    = 3'd1,
        ST_REJECT_CAP = 3'd2,
        ST_EMPTY_KEY  = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_SATURATED  = 3'd5
    } status_t;

    // One classified transaction waiting for the back end
    typedef struct packed {
        logic                     op;
        logic [KEY_W-1:0]         key;
        logic signed [LVL_W-1:0]  value;
        logic [TIME_W-1:0]        step_len;
        net_t                     net_rate;
    } work_item_t;

    typedef struct packed {
        logic                     start;
        logic                     op;
        logic signed [LVL_W-1:0]  value;
        logic [TIME_W-1:0]        step_len;
    } delta_req_t;

    typedef struct packed {
        logic   done;
        delta_t delta;
    } delta_rsp_t;

endpackage

`default_nettype wire

@@ sv/psa_ram.sv @@
// Generic single write port, single read port RAM with registered read data
`default_nettype none

module psa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                    wdata,
    input  wire logic                                re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/psa_delta.sv @@
// Multi-cycle unit: delta = round(rate * step / ticks per second), held at 2^50
`default_nettype none

module psa_delta #(
    parameter int unsigned TICKS_PER_SECOND = psa_pkg::TICKS_PER_SECOND_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire psa_pkg::delta_req_t  req,
    output psa_pkg::delta_rsp_t       rsp
);

    import psa_pkg::*;

    localparam logic [31:0] DIVISOR = 32'(64'(TICKS_PER_SECOND) * 64'd2);
    localparam int DW     = $clog2(64'(DIVISOR) + 64'd1);
    localparam int DIG_W  = 17;
    localparam int DIGITS = MAG_W / DIG_W;
    localparam int XW     = DW + DIG_W;
    localparam int EST_W  = DIG_W + 1;
    localparam int RCP_W  = EST_W + 1;
    localparam int CNT_W  = $clog2(DIGITS);
    localparam logic [63:0]   RECIP = (64'd1 << (EST_W + DW - 1)) / 64'(DIVISOR);
    localparam logic [XW-1:0] DIV_1 = XW'(64'(DIVISOR));
    localparam logic [XW-1:0] DIV_2 = XW'(64'(DIVISOR) * 64'd2);

    typedef enum logic [7:0] {
        D_IDLE = 8'b00000001,
        D_MLO  = 8'b00000010,
        D_MHI  = 8'b00000100,
        D_NUM  = 8'b00001000,
        D_PREP = 8'b00010000,
        D_EST  = 8'b00100000,
        D_COR  = 8'b01000000,
        D_FIN  = 8'b10000000
    } dstate_t;

    dstate_t state_reg, state_next;

    logic [LVL_W-1:0]  mag_in_reg;
    logic              neg_reg;
    logic [TIME_W-1:0] step_reg;
    logic [55:0]       prod_lo_reg, prod_hi_reg;
    logic [PROD_W-1:0] num_reg;
    logic [DW-1:0]     rem_reg;
    logic [MAG_W-1:0]  shf_reg, quo_reg;
    logic [XW-1:0]     x_reg;
    logic [DIG_W-1:0]  qe_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  cnt_reg;
    delta_t            delta_reg;
    logic              done_reg;

    logic [23:0]       mul_a;
    logic [55:0]       mul_p;
    logic [PROD_W-1:0] prod_sum, num_next;
    logic [XW-1:0]     x_cur;
    logic [EST_W+RCP_W-1:0] est_p;
    logic [XW-1:0]     rem_cor, rem_fix;
    logic              ge_one, ge_two;
    logic [DIG_W-1:0]  q_cor;
    logic [MAG_W-1:0]  mag_fin;

    // Shared 24 x 32 multiplier over the two halves of the rate magnitude
    assign mul_a = (state_reg == D_MLO) ? mag_in_reg[23:0] : mag_in_reg[47:24];
    assign mul_p = 56'(mul_a) * 56'(step_reg);

    // Rounded numerator 2 * rate * step + ticks
    assign prod_sum = {2'b00, prod_hi_reg, 24'b0} + {26'b0, prod_lo_reg};
    assign num_next = {prod_sum[PROD_W-2:0], 1'b0} + PROD_W'(TICKS_PER_SECOND);

    // Reciprocal estimate of one quotient digit, at most two below the true digit
    assign x_cur = {rem_reg, shf_reg[MAG_W-1 -: DIG_W]};
    assign est_p = (EST_W+RCP_W)'(x_cur[XW-1:DW-1]) * (EST_W+RCP_W)'(RECIP[RCP_W-1:0]);

    // Correct the digit against one and two divisors
    assign rem_cor = x_reg - XW'(qe_reg) * DIV_1;
    assign ge_two  = rem_cor >= DIV_2;
    assign ge_one  = rem_cor >= DIV_1;
    assign q_cor   = qe_reg + (ge_two ? DIG_W'(2) : (ge_one ? DIG_W'(1) : DIG_W'(0)));
    assign rem_fix = rem_cor - (ge_two ? DIV_2 : (ge_one ? DIV_1 : '0));

    assign mag_fin = (ovf_reg || quo_reg > DMAX_MAG) ? DMAX_MAG : quo_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE: begin
                if (req.start && req.op == OP_RATE) begin
                    state_next = D_MLO;
                end
            end
            D_MLO:  state_next = D_MHI;
            D_MHI:  state_next = D_NUM;
            D_NUM:  state_next = D_PREP;
            D_PREP: state_next = D_EST;
            D_EST:  state_next = D_COR;
            D_COR: begin
                if (cnt_reg == CNT_W'(DIGITS - 1)) begin
                    state_next = D_FIN;
                end else begin
                    state_next = D_EST;
                end
            end
            D_FIN:  state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (req.start) begin
                done_reg <= (req.op == OP_ADD);
            end else if (state_reg == D_FIN) begin
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            D_IDLE: begin
                if (req.start) begin
                    neg_reg    <= req.value[LVL_W-1];
                    mag_in_reg <= req.value[LVL_W-1] ? LVL_W'(-req.value) : req.value;
                    step_reg   <= req.step_len;
                    delta_reg  <= DELTA_W'(req.value);
                end
            end
            D_MLO: prod_lo_reg <= mul_p;
            D_MHI: prod_hi_reg <= mul_p;
            D_NUM: num_reg     <= num_next;
            D_PREP: begin
                ovf_reg <= 32'(num_reg[PROD_W-1:MAG_W]) >= DIVISOR;
                rem_reg <= num_reg[MAG_W+DW-1:MAG_W];
                shf_reg <= num_reg[MAG_W-1:0];
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            D_EST: begin
                x_reg   <= x_cur;
                qe_reg  <= est_p[EST_W+DIG_W-1:EST_W];
                shf_reg <= {shf_reg[MAG_W-DIG_W-1:0], {DIG_W{1'b0}}};
            end
            D_COR: begin
                rem_reg <= rem_fix[DW-1:0];
                quo_reg <= {quo_reg[MAG_W-DIG_W-1:0], q_cor};
                cnt_reg <= cnt_reg + 1'b1;
            end
            D_FIN: begin
                delta_reg <= neg_reg ? -$signed({1'b0, mag_fin}) : $signed({1'b0, mag_fin});
            end
            default: ;
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.delta = delta_reg;

endmodule

`default_nettype wire

@@ sv/psa_front.sv @@
// Front end: accepts input transactions, tracks the time step and net rate, queues work
`default_nettype none

module psa_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         in_op,
    input  wire logic [psa_pkg::KEY_W-1:0]    in_key,
    input  wire logic signed [psa_pkg::LVL_W-1:0] in_value,
    input  wire logic                         in_first,
    input  wire logic [psa_pkg::TIME_W-1:0]   in_now,
    output logic                              q_valid,
    input  wire logic                         q_pop,
    output psa_pkg::work_item_t               q_item
);

    import psa_pkg::*;

    logic [TIME_W-1:0] prev_time_reg, step_len_reg;
    net_t              rate_sum_reg;
    work_item_t        queue_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;

    logic              accept;
    logic              new_step;
    logic [TIME_W-1:0] step_next;
    net_t              base_sum;
    logic signed [NET_W:0] raw_sum;
    net_t              rate_sum_next;
    work_item_t        item_next;

    assign s_ready = (count_reg != 2'd2);
    assign accept  = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = queue_reg[rd_ptr_reg];

    // Start of step and saturating net rate
    always_comb begin
        new_step  = (in_op == OP_RATE) && in_first;
        step_next = new_step ? (in_now - prev_time_reg) : step_len_reg;
        base_sum  = new_step ? '0 : rate_sum_reg;
        raw_sum   = (NET_W+1)'(base_sum) + (NET_W+1)'(in_value);
        priority if (in_op != OP_RATE) begin
            rate_sum_next = rate_sum_reg;
        end else if (raw_sum > (NET_W+1)'(NET_MAX)) begin
            rate_sum_next = NET_MAX;
        end else if (raw_sum < (NET_W+1)'(NET_MIN)) begin
            rate_sum_next = NET_MIN;
        end else begin
            rate_sum_next = raw_sum[NET_W-1:0];
        end
        item_next.op       = in_op;
        item_next.key      = in_key;
        item_next.value    = in_value;
        item_next.step_len = step_next;
        item_next.net_rate = rate_sum_next;
    end

    // Step tracking and queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg <= '0;
            step_len_reg  <= '0;
            rate_sum_reg  <= '0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= 2'd0;
        end else begin
            if (accept) begin
                if (new_step) begin
                    prev_time_reg <= in_now;
                end
                step_len_reg <= step_next;
                rate_sum_reg <= rate_sum_next;
                wr_ptr_reg   <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, accept} - {1'b0, q_pop};
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (accept) begin
            queue_reg[wr_ptr_reg] <= item_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/psa_back.sv @@
// Back end: key search, capacity check, level update and result register
`default_nettype none

module psa_back #(
    parameter int PARTITIONS = psa_pkg::PARTITIONS_DEF,
    parameter int unsigned TICKS_PER_SECOND = psa_pkg::TICKS_PER_SECOND_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [psa_pkg::LVL_W-1:0]   capacity,
    input  wire logic                        q_valid,
    output logic                             q_pop,
    input  wire psa_pkg::work_item_t         q_item,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [2:0]                       out_status,
    output logic [psa_pkg::LVL_W-1:0]        out_plevel,
    output logic [psa_pkg::LVL_W-1:0]        out_total,
    output logic [psa_pkg::NET_W-1:0]        out_net
);

    import psa_pkg::*;

    localparam int IW   = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CW   = $clog2(PARTITIONS + 1);
    localparam int SUMW = LVL_W + $clog2(PARTITIONS) + 1;
    localparam int EW   = LVL_W + 6;

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_SCAN  = 6'b000010,
        B_WAITD = 6'b000100,
        B_EVAL  = 6'b001000,
        B_APPLY = 6'b010000,
        B_OUT   = 6'b100000
    } bstate_t;

    bstate_t state_reg, state_next;

    work_item_t        item_reg;
    logic [CW-1:0]     cnt_reg;
    logic              found_reg, free_reg;
    logic [IW-1:0]     found_idx_reg, free_idx_reg;
    logic [PARTITIONS-1:0] valid_reg;
    logic [SUMW-1:0]   exact_reg;
    level_t            total_reg;
    status_t           status_reg;
    level_t            new_lvl_reg, old_lvl_reg, plevel_reg;
    logic              changed_reg, create_reg, sat_reg;
    logic              m_valid_reg;
    logic [2:0]        o_status_reg;
    level_t            o_plevel_reg, o_total_reg;
    net_t              o_net_reg;

    delta_req_t        dreq;
    delta_rsp_t        drsp;
    logic [KEY_W-1:0]  key_rd;
    level_t            lvl_rd;
    logic              scan_re, lvl_re;
    logic [IW-1:0]     scan_idx, ent_idx;
    logic              ent_valid, ent_hit;
    logic [IW-1:0]     lvl_waddr;
    logic              lvl_we, key_we;

    // Evaluation signals
    level_t            old_lvl;
    logic signed [EW-1:0] delta_ext, cap_sum, lvl_sum;
    logic              fits, allow;
    status_t           ev_status;
    level_t            ev_new, ev_plevel;
    logic              ev_changed, ev_create, ev_sat;
    logic [SUMW-1:0]   exact_next;
    logic              total_over;

    psa_delta #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_delta (
        .aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp)
    );

    psa_ram #(.WIDTH(KEY_W), .DEPTH(PARTITIONS)) u_key_ram (
        .aclk(aclk), .we(key_we), .waddr(free_idx_reg), .wdata(item_reg.key),
        .re(scan_re), .raddr(scan_idx), .rdata(key_rd)
    );

    psa_ram #(.WIDTH(LVL_W), .DEPTH(PARTITIONS)) u_lvl_ram (
        .aclk(aclk), .we(lvl_we), .waddr(lvl_waddr), .wdata(new_lvl_reg),
        .re(lvl_re), .raddr(found_idx_reg), .rdata(lvl_rd)
    );

    assign q_pop = (state_reg == B_IDLE) && q_valid && !m_valid_reg;

    assign dreq.start    = q_pop;
    assign dreq.op       = q_item.op;
    assign dreq.value    = q_item.value;
    assign dreq.step_len = q_item.step_len;

    // Key search: one entry read per cycle, compared in the cycle after its read
    assign scan_idx  = cnt_reg[IW-1:0];
    assign scan_re   = (state_reg == B_SCAN) && (cnt_reg != CW'(PARTITIONS));
    assign ent_idx   = IW'(cnt_reg - 1'b1);
    assign ent_valid = valid_reg[ent_idx];
    assign ent_hit   = ent_valid && (item_reg.key != '0) && (key_rd == item_reg.key);

    assign lvl_re    = (state_reg == B_WAITD) && drsp.done;
    assign lvl_we    = (state_reg == B_APPLY) && changed_reg;
    assign key_we    = (state_reg == B_APPLY) && create_reg;
    assign lvl_waddr = create_reg ? free_idx_reg : found_idx_reg;

    // Capacity check and level arithmetic
    always_comb begin
        old_lvl   = found_reg ? lvl_rd : '0;
        delta_ext = EW'(drsp.delta);
        cap_sum   = $signed({6'b0, total_reg}) + delta_ext;
        lvl_sum   = $signed({6'b0, old_lvl}) + delta_ext;
        fits      = cap_sum <= $signed({6'b0, capacity});
        allow     = fits || (item_reg.op == OP_RATE && item_reg.value < 0);
        ev_status  = ST_APPLIED;
        ev_new     = old_lvl;
        ev_plevel  = '0;
        ev_changed = 1'b0;
        ev_create  = 1'b0;
        ev_sat     = 1'b0;
        priority if (!allow) begin
            ev_status = ST_REJECT_CAP;
            ev_plevel = old_lvl;
        end else if (found_reg) begin
            ev_status = ST_APPLIED;
            if (item_reg.op == OP_RATE || lvl_sum >= 0) begin
                ev_changed = 1'b1;
                priority if (lvl_sum < 0) begin
                    ev_new = '0;
                end else if (lvl_sum > $signed({6'b0, LVL_MAX})) begin
                    ev_new = LVL_MAX;
                    ev_sat = 1'b1;
                end else begin
                    ev_new = lvl_sum[LVL_W-1:0];
                end
            end
            ev_plevel = ev_new;
        end else if (item_reg.key == '0) begin
            ev_status = ST_EMPTY_KEY;
        end else if (!free_reg) begin
            ev_status = ST_TABLE_FULL;
        end else begin
            ev_status  = ST_CREATED;
            ev_changed = 1'b1;
            ev_create  = 1'b1;
            priority if (delta_ext <= 0) begin
                ev_new = '0;
            end else if (delta_ext > $signed({6'b0, LVL_MAX})) begin
                ev_new = LVL_MAX;
                ev_sat = 1'b1;
            end else begin
                ev_new = delta_ext[LVL_W-1:0];
            end
            ev_plevel = ev_new;
        end
    end

    assign exact_next = exact_reg + SUMW'(new_lvl_reg) - SUMW'(old_lvl_reg);
    assign total_over = exact_reg > SUMW'(LVL_MAX);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (q_pop) state_next = B_SCAN;
            B_SCAN:  if (cnt_reg == CW'(PARTITIONS)) state_next = B_WAITD;
            B_WAITD: if (drsp.done) state_next = B_EVAL;
            B_EVAL:  state_next = B_APPLY;
            B_APPLY: state_next = B_OUT;
            B_OUT:   state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            valid_reg   <= '0;
            exact_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_APPLY && create_reg) begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (state_reg == B_APPLY && changed_reg) begin
                exact_reg <= exact_next;
            end
            if (state_reg == B_OUT && changed_reg) begin
                total_reg <= total_over ? LVL_MAX : exact_reg[LVL_W-1:0];
            end
            if (state_reg == B_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Work registers and result payload
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: begin
                if (q_pop) begin
                    item_reg  <= q_item;
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                    free_reg  <= 1'b0;
                end
            end
            B_SCAN: begin
                if (cnt_reg != '0) begin
                    if (ent_hit && !found_reg) begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= ent_idx;
                    end
                    if (!ent_valid && !free_reg) begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= ent_idx;
                    end
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            B_EVAL: begin
                status_reg  <= ev_status;
                new_lvl_reg <= ev_new;
                old_lvl_reg <= ev_create ? '0 : old_lvl;
                plevel_reg  <= ev_plevel;
                changed_reg <= ev_changed;
                create_reg  <= ev_create;
                sat_reg     <= ev_sat;
            end
            B_OUT: begin
                o_status_reg <= (changed_reg && (sat_reg || total_over)) ?
                                ST_SATURATED : status_reg;
                o_plevel_reg <= plevel_reg;
                o_total_reg  <= changed_reg ?
                                (total_over ? LVL_MAX : exact_reg[LVL_W-1:0]) : total_reg;
                o_net_reg    <= item_reg.net_rate;
            end
            default: ;
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign out_status = o_status_reg;
    assign out_plevel = o_plevel_reg;
    assign out_total  = o_total_reg;
    assign out_net    = o_net_reg;

endmodule

`default_nettype wire

@@ sv/partitioned_storage_accounting.sv @@
// Top level of the partitioned storage accounting block: ports, capacity register, front and back
//
//  channel   direction  handshake              payload
//  s_axis    in         s_axis_tvalid/tready   tuser: opcode, first_of_step; tdata: key, rate, time
//  m_axis    out        m_axis_tvalid/tready   tuser: status; tdata: levels, net rate
//  apb       in/out     psel/penable/pready    storage_capacity at byte address 0
//
// Each transaction holds the back end through the key search, which reads one entry a cycle, then
// the wait for the delta, evaluate, apply, output and the result handshake.
// A rate delta is computed once the back end takes the transaction (multiply, then three
// reciprocal quotient digits); the key search covers it from 10 partitions up.
// The front queue holds two transactions, so input is taken while the back end works.
// Synchronous active-low reset clears the table valid bits, totals and step state.
// The result register holds until m_axis_tready; the back end stalls meanwhile.
`default_nettype none

module partitioned_storage_accounting #(
    parameter int PARTITIONS = psa_pkg::PARTITIONS_DEF,
    parameter int unsigned TICKS_PER_SECOND = psa_pkg::TICKS_PER_SECOND_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,   // partition_key, rate_or_amount, now_time
    input  wire logic [1:0]   s_axis_tuser,   // opcode, first_of_step
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [151:0]      m_axis_tdata,   // partition_level, total_level, net_rate, zeros
    output logic [2:0]        m_axis_tuser,   // status
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    import psa_pkg::*;

    level_t     cap_reg;
    logic       q_valid, q_pop;
    work_item_t q_item;
    logic [2:0] out_status;
    level_t     out_plevel, out_total;
    logic [NET_W-1:0] out_net;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == 1'b0) ? {16'b0, cap_reg} : 64'b0;

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr[3] == 1'b0) begin
            cap_reg <= pwdata[LVL_W-1:0];
        end
    end

    psa_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
        .in_op(s_axis_tuser[0]), .in_key(s_axis_tdata[15:0]),
        .in_value(s_axis_tdata[63:16]), .in_first(s_axis_tuser[1]),
        .in_now(s_axis_tdata[95:64]),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    psa_back #(.PARTITIONS(PARTITIONS), .TICKS_PER_SECOND(TICKS_PER_SECOND)) u_back (
        .aclk(aclk), .aresetn(aresetn), .capacity(cap_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .out_status(out_status), .out_plevel(out_plevel),
        .out_total(out_total), .out_net(out_net)
    );

    assign m_axis_tuser = out_status;
    assign m_axis_tdata = {3'b000, out_net, out_total, out_plevel};

endmodule

`default_nettype wire
